// ----- hdl/gbdp_pkg.sv -----
package gbdp_pkg;

  localparam int TABLE_SLOTS     = 8;
  localparam int WORDS_PER_BLOCK = 16;
  localparam int MAX_CODE_LEN    = 16;

  localparam int SLOT_W   = 3;
  localparam int WORD_W   = 32;
  localparam int WIDTH_W  = 6;
  localparam int CODE_W   = 16;
  localparam int LEN_W    = 5;
  localparam int COST_W   = 6;
  localparam int BCOST_W  = 10;
  localparam int CFG_W    = 4;

  localparam int IDX_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int POS_W    = $clog2(WORDS_PER_BLOCK);
  localparam int LEVELS   = $clog2(TABLE_SLOTS);
  localparam int LEAVES   = 1 << LEVELS;

  localparam logic [WIDTH_W-1:0] OUTLIER_BITS = WIDTH_W'(32);
  localparam logic [BCOST_W-1:0] COST_MAX     = BCOST_W'(1023);
  localparam logic [POS_W-1:0]   LAST_POS     = POS_W'(WORDS_PER_BLOCK - 1);
  localparam logic [LEN_W-1:0]   MAX_LEN      = LEN_W'(MAX_CODE_LEN);

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_WORD = 1'b1
  } kind_e;

  typedef struct packed {
    logic [WORD_W-1:0]  base;
    logic [WIDTH_W-1:0] width;
    logic [CODE_W-1:0]  code;
    logic [LEN_W-1:0]   len;
  } entry_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic [WORD_W-1:0]  base;
    logic [WIDTH_W-1:0] width;
    logic [CODE_W-1:0]  code;
    logic [LEN_W-1:0]   len;
  } tbl_wr_t;

  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] delta;
  } match_t;

endpackage

// ----- hdl/gbdp_table.sv -----
module gbdp_table
  import gbdp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  tbl_wr_t wr_i,
  output entry_t  entries_o [TABLE_SLOTS]
);

  entry_t entries_q [TABLE_SLOTS];
  entry_t wr_entry;
  logic   wr_hit;

  always_comb begin
    wr_entry.base  = wr_i.base;
    wr_entry.width = (wr_i.width > OUTLIER_BITS) ? OUTLIER_BITS : wr_i.width;
    wr_entry.len   = (wr_i.len > MAX_LEN) ? MAX_LEN : wr_i.len;
    wr_entry.code  = wr_i.code & ~({CODE_W{1'b1}} << wr_entry.len);
    wr_hit         = wr_i.en && (int'(wr_i.slot) < TABLE_SLOTS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TABLE_SLOTS; k++) begin
        entries_q[k] <= '0;
      end
    end else if (wr_hit) begin
      entries_q[wr_i.slot[IDX_W-1:0]] <= wr_entry;
    end
  end

  assign entries_o = entries_q;

endmodule

// ----- hdl/gbdp_search.sv -----
module gbdp_search
  import gbdp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [SLOT_W-1:0]  entry_slot_i,
  input  logic [WORD_W-1:0]  entry_base_i,
  input  logic [WIDTH_W-1:0] entry_width_i,
  input  logic [CODE_W-1:0]  entry_code_i,
  input  logic [LEN_W-1:0]   entry_code_len_i,
  input  logic [WORD_W-1:0]  word_value_i,
  input  logic [CFG_W-1:0]   bases_in_use_i,
  input  entry_t             entries_i [TABLE_SLOTS],
  output tbl_wr_t            tbl_wr_o,
  output match_t             match_o,
  input  logic               match_ready_i
);

  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] diff;
  } cand_t;

  logic               s1_valid_q;
  logic               s1_kind_q;
  logic [SLOT_W-1:0]  s1_slot_q;
  logic [WORD_W-1:0]  s1_base_q;
  logic [WIDTH_W-1:0] s1_width_q;
  logic [CODE_W-1:0]  s1_code_q;
  logic [LEN_W-1:0]   s1_len_q;
  logic [WORD_W-1:0]  s1_word_q;
  logic               match_valid_q;
  logic [IDX_W-1:0]   match_idx_q;
  logic [WORD_W-1:0]  match_delta_q;
  logic               s1_free;
  logic               s2_free;
  cand_t              node [LEVELS+1][LEAVES];

  function automatic logic beats(cand_t b, cand_t a);
    return b.valid && (!a.valid || (b.diff < a.diff) ||
                       ((b.diff == a.diff) && (b.base > a.base)));
  endfunction

  assign s2_free    = !match_valid_q || match_ready_i;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_ready_o = s1_free;

  always_comb begin
    for (int k = 0; k < LEAVES; k++) begin
      node[0][k] = '0;
      if (k < TABLE_SLOTS) begin
        node[0][k].valid = (k == 0) || (k < int'(bases_in_use_i));
        node[0][k].idx   = IDX_W'(k);
        node[0][k].base  = entries_i[k].base;
        node[0][k].diff  = (s1_word_q >= entries_i[k].base) ?
                           (s1_word_q - entries_i[k].base) :
                           (entries_i[k].base - s1_word_q);
      end
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int k = 0; k < LEAVES; k++) begin
        node[l+1][k] = '0;
      end
      for (int k = 0; k < (LEAVES >> (l + 1)); k++) begin
        node[l+1][k] = beats(node[l][2*k+1], node[l][2*k]) ?
                       node[l][2*k+1] : node[l][2*k];
      end
    end
  end

  always_comb begin
    tbl_wr_o.en    = s1_valid_q && (s1_kind_q == KIND_LOAD) && s2_free;
    tbl_wr_o.slot  = s1_slot_q;
    tbl_wr_o.base  = s1_base_q;
    tbl_wr_o.width = s1_width_q;
    tbl_wr_o.code  = s1_code_q;
    tbl_wr_o.len   = s1_len_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      match_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        match_valid_q <= s1_valid_q && (s1_kind_q == KIND_WORD);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_kind_q  <= kind_i;
      s1_slot_q  <= entry_slot_i;
      s1_base_q  <= entry_base_i;
      s1_width_q <= entry_width_i;
      s1_code_q  <= entry_code_i;
      s1_len_q   <= entry_code_len_i;
      s1_word_q  <= word_value_i;
    end
    if (s2_free) begin
      match_idx_q   <= node[LEVELS][0].idx;
      match_delta_q <= node[LEVELS][0].diff;
    end
  end

  always_comb begin
    match_o.valid = match_valid_q;
    match_o.idx   = match_idx_q;
    match_o.delta = match_delta_q;
  end

endmodule

// ----- hdl/gbdp_cost.sv -----
module gbdp_cost
  import gbdp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  match_t             match_i,
  output logic               match_ready_o,
  input  entry_t             entries_i [TABLE_SLOTS],
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SLOT_W-1:0]  base_slot_o,
  output logic               in_range_o,
  output logic [WORD_W-1:0]  delta_magnitude_o,
  output logic [CODE_W-1:0]  pointer_code_o,
  output logic [LEN_W-1:0]   pointer_code_len_o,
  output logic [COST_W-1:0]  word_cost_o,
  output logic               block_done_o,
  output logic [BCOST_W-1:0] block_cost_o
);

  logic               out_valid_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               fits_q;
  logic [WORD_W-1:0]  delta_q;
  logic [CODE_W-1:0]  code_q;
  logic [LEN_W-1:0]   len_q;
  logic [COST_W-1:0]  cost_q;
  logic               done_q;
  logic [BCOST_W-1:0] bcost_q;
  logic [POS_W-1:0]   pos_q;
  logic [BCOST_W-1:0] run_q;

  entry_t             sel;
  logic               fits;
  logic [COST_W-1:0]  cost;
  logic               done;
  logic [BCOST_W:0]   run_sum;
  logic [BCOST_W:0]   blk_sum;
  logic [BCOST_W-1:0] run_sat;
  logic [BCOST_W-1:0] blk_sat;
  logic               take;

  assign match_ready_o = !out_valid_q || out_ready_i;
  assign take          = match_i.valid && match_ready_o;

  always_comb begin
    sel     = entries_i[match_i.idx];
    fits    = (sel.width >= OUTLIER_BITS) || ((match_i.delta >> sel.width) == '0);
    cost    = COST_W'(sel.len) + (fits ? sel.width : OUTLIER_BITS);
    done    = (pos_q == LAST_POS);
    run_sum = {1'b0, run_q} + (BCOST_W+1)'(cost);
    blk_sum = run_sum + (BCOST_W+1)'(WORDS_PER_BLOCK);
    run_sat = (run_sum > {1'b0, COST_MAX}) ? COST_MAX : run_sum[BCOST_W-1:0];
    blk_sat = (blk_sum > {1'b0, COST_MAX}) ? COST_MAX : blk_sum[BCOST_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      run_q       <= '0;
    end else begin
      if (match_ready_o) begin
        out_valid_q <= match_i.valid;
      end
      if (take) begin
        if (done) begin
          pos_q <= '0;
          run_q <= '0;
        end else begin
          pos_q <= pos_q + POS_W'(1);
          run_q <= run_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      slot_q  <= SLOT_W'(match_i.idx);
      fits_q  <= fits;
      delta_q <= match_i.delta;
      code_q  <= sel.code;
      len_q   <= sel.len;
      cost_q  <= cost;
      done_q  <= done;
      bcost_q <= done ? blk_sat : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign base_slot_o        = slot_q;
  assign in_range_o         = fits_q;
  assign delta_magnitude_o  = delta_q;
  assign pointer_code_o     = code_q;
  assign pointer_code_len_o = len_q;
  assign word_cost_o        = cost_q;
  assign block_done_o       = done_q;
  assign block_cost_o       = bcost_q;

endmodule

// ----- hdl/global_base_delta_word_packer.sv -----
// Global base-delta word packer.
// The input channel (in_valid_i/in_ready_o) carries load items and word items.
// A load item writes one entry of the eight-entry base table and gives no result.
// A word item finds the closest enabled base and gives one result item on the
// output channel (out_valid_o/out_ready_i) with the slot, delta, fit flag, code
// and bit cost; every sixteenth word also carries the block cost.
// The configuration register bases_in_use is written with cfg_we_i and
// cfg_wdata_i; the user must write it only while the block is idle, which
// the block itself does not enforce. A result passes through three registers
// after its input item is accepted: the input register at the accepting edge,
// the match register after the closest-base search tree, and the result
// register after the cost and block accounting logic.
// Throughput is one item per cycle while the output is not stalled; the three
// registers form a stall-aware pipeline, and a stalled output holds its result
// while bubbles ahead of it still fill. The input stops accepting once all
// three are full and out_ready_i is low. Reset clears the base table to zero,
// sets bases_in_use to one, and restarts block counting at the first word.
module global_base_delta_word_packer
  import gbdp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [SLOT_W-1:0]  entry_slot_i,
  input  logic [WORD_W-1:0]  entry_base_i,
  input  logic [WIDTH_W-1:0] entry_width_i,
  input  logic [CODE_W-1:0]  entry_code_i,
  input  logic [LEN_W-1:0]   entry_code_len_i,
  input  logic [WORD_W-1:0]  word_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SLOT_W-1:0]  base_slot_o,
  output logic               in_range_o,
  output logic [WORD_W-1:0]  delta_magnitude_o,
  output logic [CODE_W-1:0]  pointer_code_o,
  output logic [LEN_W-1:0]   pointer_code_len_o,
  output logic [COST_W-1:0]  word_cost_o,
  output logic               block_done_o,
  output logic [BCOST_W-1:0] block_cost_o
);

  logic [CFG_W-1:0] bases_in_use_q;
  entry_t           entries [TABLE_SLOTS];
  tbl_wr_t          tbl_wr;
  match_t           match;
  logic             match_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bases_in_use_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      bases_in_use_q <= cfg_wdata_i;
    end
  end

  gbdp_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .entries_o (entries)
  );

  gbdp_search u_search (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .entry_slot_i     (entry_slot_i),
    .entry_base_i     (entry_base_i),
    .entry_width_i    (entry_width_i),
    .entry_code_i     (entry_code_i),
    .entry_code_len_i (entry_code_len_i),
    .word_value_i     (word_value_i),
    .bases_in_use_i   (bases_in_use_q),
    .entries_i        (entries),
    .tbl_wr_o         (tbl_wr),
    .match_o          (match),
    .match_ready_i    (match_ready)
  );

  gbdp_cost u_cost (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .match_i            (match),
    .match_ready_o      (match_ready),
    .entries_i          (entries),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .base_slot_o        (base_slot_o),
    .in_range_o         (in_range_o),
    .delta_magnitude_o  (delta_magnitude_o),
    .pointer_code_o     (pointer_code_o),
    .pointer_code_len_o (pointer_code_len_o),
    .word_cost_o        (word_cost_o),
    .block_done_o       (block_done_o),
    .block_cost_o       (block_cost_o)
  );

endmodule
